FILE: rtl/core/pl0_pkg.sv
// Shared types, constants and helper functions of the PL/0 p-code step engine.
`default_nettype none

package pl0_pkg;

	localparam int STACK_DEPTH   = 1024;
	localparam int PROGRAM_DEPTH = 1024;
	localparam int MAX_LEVEL     = 15;

	localparam int SW = $clog2(STACK_DEPTH);
	// PROGRAM_DEPTH is a power of two that fills the 10-bit next_pc field,
	// so wrapping a target is taking its low bits.
	localparam int PC_W = $clog2(PROGRAM_DEPTH);
	localparam int WW   = 34;

	typedef enum logic [3:0] {
		OP_LIT = 4'd0,
		OP_OPR = 4'd1,
		OP_LOD = 4'd2,
		OP_STO = 4'd3,
		OP_CAL = 4'd4,
		OP_INT = 4'd5,
		OP_JMP = 4'd6,
		OP_JPC = 4'd7
	} op_code_t;

	localparam logic [31:0] OPR_RTN = 32'd0;
	localparam logic [31:0] OPR_ADD = 32'd2;
	localparam logic [31:0] OPR_SUB = 32'd3;
	localparam logic [31:0] OPR_MUL = 32'd4;
	localparam logic [31:0] OPR_NEQ = 32'd9;
	localparam logic [31:0] OPR_GTR = 32'd12;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_INSTR = 2'd1,
		ERR_OPER  = 2'd2,
		ERR_RANGE = 2'd3
	} err_code_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_WALK_RD,
		ST_POST,
		ST_RTN1,
		ST_RTN2,
		ST_ALU1,
		ST_ALU2,
		ST_LOD2,
		ST_STO2,
		ST_CAL2,
		ST_CAL3,
		ST_JPC2,
		ST_TOP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic          we;
		logic [SW-1:0] waddr;
		logic [31:0]   wdata;
		logic          re;
		logic [SW-1:0] raddr;
	} mem_req_t;

	function automatic logic signed [WW-1:0] ext_u(input logic [SW-1:0] v);
		ext_u = $signed({{(WW-SW){1'b0}}, v});
	endfunction

	function automatic logic signed [WW-1:0] ext_s(input logic [31:0] v);
		ext_s = $signed({{(WW-32){v[31]}}, v});
	endfunction

	function automatic logic in_stk(input logic signed [WW-1:0] v);
		in_stk = (v >= 0) && (v < WW'(STACK_DEPTH));
	endfunction

	function automatic logic [31:0] alu(input logic [31:0] code, input logic [31:0] x,
			input logic [31:0] y);
		case (code)
			OPR_ADD: alu = x + y;
			OPR_SUB: alu = x - y;
			OPR_MUL: alu = x * y;
			OPR_NEQ: alu = {31'd0, x != y};
			OPR_GTR: alu = {31'd0, $signed(x) > $signed(y)};
			default: alu = 32'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pl0_pcode_stack_machine_step.sv
// Top level of the PL/0 p-code step engine: sequencer, machine registers and result register.
//
//  channel | direction | fields                                                 | handshake
//  in      | input     | op, level, argument                                    | in_valid/in_ready
//  out     | output    | next_pc, top_value, halted, final_value, error_code    | out_valid/out_ready
//
// After reset the sequencer sweeps the stack memory, one entry a cycle, over all 1024 entries,
// and in_ready stays low until that pass is done.
// LOD, STO and CAL walk one static link level at a time, each through a read of the single
// registered read port of the stack memory; a step of a halted machine skips execution and
// only reads the top of the stack.
// One instruction is in work at a time; a result held in the output register does not stop
// the next transfer, but a second result waits until the first one is taken.
`default_nettype none

module pl0_pcode_stack_machine_step import pl0_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [3:0]  op,
	input  wire logic [3:0]  level,
	input  wire logic [31:0] argument,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [9:0]  next_pc,
	output      logic [31:0] top_value,
	output      logic        halted,
	output      logic [31:0] final_value,
	output      logic [1:0]  error_code
);

	state_t          state_q, state_d;
	logic [SW-1:0]   top_q, top_d;
	logic [SW-1:0]   base_q, base_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic            halt_q, halt_d;
	logic [1:0]      err_q, err_d;
	logic [SW-1:0]   clr_q;
	logic [3:0]      cnt_q, cnt_d;
	logic [31:0]     b_q, b_d;
	logic [31:0]     tmp_q, tmp_d;
	logic [SW-1:0]   addr_q, addr_d;
	logic [31:0]     fin_q;
	logic [3:0]      op_q;
	logic [3:0]      lvl_q;
	logic [31:0]     arg_q;
	logic            load_out;
	mem_req_t        req;
	logic [31:0]     rdata;

	logic signed [WW-1:0] top_x, base_x, arg_x, b_x, lnk_sum;
	logic [31:0]          arg_m1;

	assign top_x   = ext_u(top_q);
	assign base_x  = ext_u(base_q);
	assign arg_x   = ext_s(arg_q);
	assign b_x     = ext_s(b_q);
	assign lnk_sum = b_x + arg_x;
	assign arg_m1  = arg_q - 32'd1;

	assign in_ready = (state_q == ST_IDLE);

	pl0_stack_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_comb begin
		state_d  = state_q;
		top_d    = top_q;
		base_d   = base_q;
		pc_d     = pc_q;
		halt_d   = halt_q;
		err_d    = err_q;
		cnt_d    = cnt_q;
		b_d      = b_q;
		tmp_d    = tmp_q;
		addr_d   = addr_q;
		load_out = 1'b0;
		req      = '0;

		case (state_q)
			ST_CLEAR: begin
				req.we    = 1'b1;
				req.waddr = clr_q;
				req.wdata = (clr_q == '0) ? 32'hFFFF_FFFF : 32'd0;
				if (clr_q == SW'(STACK_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cnt_d = level;
					b_d   = {{(32-SW){1'b0}}, base_q};
					if (halt_q) begin
						state_d = ST_TOP;
					end else begin
						pc_d    = pc_q + PC_W'(1);
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				state_d = ST_TOP;
				if ((op_q == OP_LIT || op_q == OP_LOD || op_q == OP_STO || op_q == OP_CAL)
						&& (lvl_q > 4'(MAX_LEVEL))) begin
					err_d  = ERR_INSTR;
					halt_d = 1'b1;
				end else begin
					case (op_q)
						OP_LIT: begin
							if (!in_stk(top_x + 1)) begin
								err_d  = ERR_RANGE;
								halt_d = 1'b1;
							end else begin
								req.we    = 1'b1;
								req.waddr = top_q + SW'(1);
								req.wdata = arg_q;
								top_d     = top_q + SW'(1);
							end
						end
						OP_OPR: begin
							if (arg_q == OPR_RTN) begin
								if (!in_stk(base_x + 2) || !in_stk(base_x - 1)) begin
									err_d  = ERR_RANGE;
									halt_d = 1'b1;
								end else begin
									req.re    = 1'b1;
									req.raddr = base_q + SW'(2);
									state_d   = ST_RTN1;
								end
							end else if (arg_q == OPR_ADD || arg_q == OPR_SUB
									|| arg_q == OPR_MUL || arg_q == OPR_NEQ
									|| arg_q == OPR_GTR) begin
								if (!in_stk(top_x - 1)) begin
									err_d  = ERR_RANGE;
									halt_d = 1'b1;
								end else begin
									req.re    = 1'b1;
									req.raddr = top_q - SW'(1);
									state_d   = ST_ALU1;
								end
							end else begin
								err_d  = ERR_OPER;
								halt_d = 1'b1;
							end
						end
						OP_LOD, OP_STO, OP_CAL: begin
							state_d = ST_WALK;
						end
						OP_INT: begin
							if (!in_stk(top_x + arg_x)) begin
								err_d  = ERR_RANGE;
								halt_d = 1'b1;
							end else begin
								top_d = top_q + arg_q[SW-1:0];
							end
						end
						OP_JMP: begin
							pc_d = arg_m1[PC_W-1:0];
						end
						OP_JPC: begin
							if (!in_stk(top_x - 1)) begin
								err_d  = ERR_RANGE;
								halt_d = 1'b1;
							end else begin
								req.re    = 1'b1;
								req.raddr = top_q;
								state_d   = ST_JPC2;
							end
						end
						default: begin
							err_d  = ERR_INSTR;
							halt_d = 1'b1;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!in_stk(b_x)) begin
					err_d   = ERR_RANGE;
					halt_d  = 1'b1;
					state_d = ST_TOP;
				end else if (cnt_q == 4'd0) begin
					state_d = ST_POST;
				end else begin
					req.re    = 1'b1;
					req.raddr = b_q[SW-1:0];
					state_d   = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				b_d     = rdata;
				cnt_d   = cnt_q - 4'd1;
				state_d = ST_WALK;
			end
			ST_POST: begin
				state_d = ST_TOP;
				addr_d  = lnk_sum[SW-1:0];
				case (op_q)
					OP_LOD: begin
						if (!in_stk(lnk_sum) || !in_stk(top_x + 1)) begin
							err_d  = ERR_RANGE;
							halt_d = 1'b1;
						end else begin
							req.re    = 1'b1;
							req.raddr = lnk_sum[SW-1:0];
							state_d   = ST_LOD2;
						end
					end
					OP_STO: begin
						if (!in_stk(lnk_sum) || !in_stk(top_x - 1)) begin
							err_d  = ERR_RANGE;
							halt_d = 1'b1;
						end else begin
							req.re    = 1'b1;
							req.raddr = top_q;
							state_d   = ST_STO2;
						end
					end
					default: begin
						if (!in_stk(top_x + 3)) begin
							err_d  = ERR_RANGE;
							halt_d = 1'b1;
						end else begin
							req.we    = 1'b1;
							req.waddr = top_q + SW'(1);
							req.wdata = b_q;
							state_d   = ST_CAL2;
						end
					end
				endcase
			end
			ST_RTN1: begin
				tmp_d     = rdata;
				req.re    = 1'b1;
				req.raddr = base_q + SW'(1);
				state_d   = ST_RTN2;
			end
			ST_RTN2: begin
				state_d = ST_TOP;
				if (!in_stk(ext_s(rdata))) begin
					err_d  = ERR_RANGE;
					halt_d = 1'b1;
				end else begin
					top_d  = base_q - SW'(1);
					pc_d   = tmp_q[PC_W-1:0];
					base_d = rdata[SW-1:0];
				end
			end
			ST_ALU1: begin
				tmp_d     = rdata;
				req.re    = 1'b1;
				req.raddr = top_q;
				state_d   = ST_ALU2;
			end
			ST_ALU2: begin
				req.we    = 1'b1;
				req.waddr = top_q - SW'(1);
				req.wdata = alu(arg_q, tmp_q, rdata);
				top_d     = top_q - SW'(1);
				state_d   = ST_TOP;
			end
			ST_LOD2: begin
				req.we    = 1'b1;
				req.waddr = top_q + SW'(1);
				req.wdata = rdata;
				top_d     = top_q + SW'(1);
				state_d   = ST_TOP;
			end
			ST_STO2: begin
				req.we    = 1'b1;
				req.waddr = addr_q;
				req.wdata = rdata;
				top_d     = top_q - SW'(1);
				state_d   = ST_TOP;
			end
			ST_CAL2: begin
				req.we    = 1'b1;
				req.waddr = top_q + SW'(2);
				req.wdata = {{(32-SW){1'b0}}, base_q};
				state_d   = ST_CAL3;
			end
			ST_CAL3: begin
				// The return address is the already advanced program counter.
				req.we    = 1'b1;
				req.waddr = top_q + SW'(3);
				req.wdata = {{(32-PC_W){1'b0}}, pc_q};
				base_d    = top_q + SW'(1);
				pc_d      = arg_q[PC_W-1:0];
				state_d   = ST_TOP;
			end
			ST_JPC2: begin
				if (rdata == 32'd0) begin
					pc_d = arg_m1[PC_W-1:0];
				end
				top_d   = top_q - SW'(1);
				state_d = ST_TOP;
			end
			ST_TOP: begin
				halt_d    = halt_q | (base_q == '0);
				req.re    = 1'b1;
				req.raddr = top_q;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			top_q     <= '0;
			base_q    <= SW'(1);
			pc_q      <= '0;
			halt_q    <= 1'b0;
			err_q     <= ERR_NONE;
			fin_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			base_q  <= base_d;
			pc_q    <= pc_d;
			halt_q  <= halt_d;
			err_q   <= err_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			// Entry one is mirrored so that the result field needs no second read port.
			if (req.we && req.waddr == SW'(1)) begin
				fin_q <= req.wdata;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		b_q    <= b_d;
		tmp_q  <= tmp_d;
		addr_q <= addr_d;
		if (in_valid && in_ready) begin
			op_q  <= op;
			lvl_q <= level;
			arg_q <= argument;
		end
		if (load_out) begin
			next_pc     <= pc_q;
			top_value   <= rdata;
			halted      <= halt_q;
			final_value <= fin_q;
			error_code  <= err_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pl0_stack_mem.sv
// Data stack memory: one write port and one registered read port.
`default_nettype none

module pl0_stack_mem import pl0_pkg::*; (
	input  wire logic        clk,
	input  wire mem_req_t    req,
	output      logic [31:0] rdata
);

	logic [31:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pl0_checker.sv
// Port-level checks of the PL/0 step engine, bound to its top level.
`default_nettype none

module pl0_checker import pl0_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [9:0]  next_pc,
	input wire logic [31:0] top_value,
	input wire logic        halted,
	input wire logic [1:0]  error_code
);

	// A result that is not taken holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(top_value)
			&& $stable(halted) && $stable(error_code))
		else $error("stalled result changed");

	// Ready is high only in the idle state, so it drops after a transfer.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transfer");

	// A reported error always comes with the halt flag.
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> halted)
		else $error("error reported without halt");

	// A halted result keeps the halt flag for as long as out_valid stays high.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |=> !out_valid || halted)
		else $error("halt flag cleared");

endmodule

bind pl0_pcode_stack_machine_step pl0_checker u_pl0_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.next_pc    (next_pc),
	.top_value  (top_value),
	.halted     (halted),
	.error_code (error_code)
);

`default_nettype wire

FILE: sim/tb.sv
// Testbench for the PL/0 p-code step engine: directed table, then random programs checked on a predictor.
`timescale 1ns / 100ps

module tb;
	import pl0_pkg::*;

	typedef struct packed {
		logic [9:0]  pc;
		logic [31:0] top;
		logic        halted;
		logic [31:0] final_val;
		logic [1:0]  err;
	} step_result_t;

	typedef struct {
		logic [3:0]   op;
		logic [3:0]   level;
		logic [31:0]  arg;
		bit           typed;
		step_result_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] op = '0;
	logic [3:0] level = '0;
	logic [31:0] argument = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [9:0] next_pc;
	logic [31:0] top_value;
	logic halted;
	logic [31:0] final_value;
	logic [1:0] error_code;

	pl0_pcode_stack_machine_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .level(level), .argument(argument),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .top_value(top_value), .halted(halted),
		.final_value(final_value), .error_code(error_code)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted machine state.
	logic [31:0] stk [STACK_DEPTH];
	longint fb, st, pc;
	bit hlt;
	logic [1:0] erg;

	step_result_t pending_results[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_cnt = 0;

	function automatic bit in_range(longint v);
		return v >= 0 && v < STACK_DEPTH;
	endfunction

	function automatic longint sval(logic [31:0] x);
		return longint'($signed(x));
	endfunction

	function automatic longint wrap_addr(longint v);
		longint m;
		m = v % PROGRAM_DEPTH;
		if (m < 0)
			m += PROGRAM_DEPTH;
		return m;
	endfunction

	// Executes one instruction on the predicted state. With commit clear it only tells
	// whether the instruction would fault or stop the machine.
	function automatic void run_instr(input logic [3:0] iop, input logic [3:0] ilvl,
			input logic [31:0] iarg, input bit commit, output logic [1:0] err,
			output bit stops);
		longint npc, nt, nb, b, addr, arg;
		longint wa [3];
		logic [31:0] wd [3];
		int nw;
		bit ok;
		npc = wrap_addr(pc + 1);
		nt = st;
		nb = fb;
		nw = 0;
		err = ERR_NONE;
		stops = 0;
		arg = sval(iarg);
		b = fb;
		ok = 1;
		if (iop == OP_LOD || iop == OP_STO || iop == OP_CAL) begin
			for (int i = 0; i < ilvl; i++) begin
				if (!in_range(b)) begin
					ok = 0;
					break;
				end
				b = sval(stk[b]);
			end
			if (!in_range(b))
				ok = 0;
		end
		if (iop <= 4 && iop != OP_OPR && ilvl > MAX_LEVEL)
			err = ERR_INSTR;
		else begin
			case (iop)
				OP_LIT: begin
					if (!in_range(st + 1))
						err = ERR_RANGE;
					else begin
						wa[0] = st + 1; wd[0] = iarg; nw = 1; nt = st + 1;
					end
				end
				OP_OPR: begin
					if (iarg == OPR_RTN) begin
						if (!in_range(fb + 2) || !in_range(fb - 1) ||
								!in_range(sval(stk[fb + 1])))
							err = ERR_RANGE;
						else begin
							nt = fb - 1;
							npc = wrap_addr(sval(stk[fb + 2]));
							nb = sval(stk[fb + 1]);
						end
					end else if (iarg inside {OPR_ADD, OPR_SUB, OPR_MUL, OPR_NEQ, OPR_GTR}) begin
						if (!in_range(st - 1))
							err = ERR_RANGE;
						else begin
							case (iarg)
								OPR_ADD: wd[0] = stk[st - 1] + stk[st];
								OPR_SUB: wd[0] = stk[st - 1] - stk[st];
								OPR_MUL: wd[0] = stk[st - 1] * stk[st];
								OPR_NEQ: wd[0] = {31'd0, stk[st - 1] != stk[st]};
								default: wd[0] = {31'd0, $signed(stk[st - 1]) > $signed(stk[st])};
							endcase
							wa[0] = st - 1; nw = 1; nt = st - 1;
						end
					end else
						err = ERR_OPER;
				end
				OP_LOD: begin
					addr = b + arg;
					if (!ok || !in_range(addr) || !in_range(st + 1))
						err = ERR_RANGE;
					else begin
						wa[0] = st + 1; wd[0] = stk[addr]; nw = 1; nt = st + 1;
					end
				end
				OP_STO: begin
					addr = b + arg;
					if (!ok || !in_range(addr) || !in_range(st - 1))
						err = ERR_RANGE;
					else begin
						wa[0] = addr; wd[0] = stk[st]; nw = 1; nt = st - 1;
					end
				end
				OP_CAL: begin
					if (!ok || !in_range(st + 3))
						err = ERR_RANGE;
					else begin
						wa[0] = st + 1; wd[0] = 32'(b);
						wa[1] = st + 2; wd[1] = 32'(fb);
						wa[2] = st + 3; wd[2] = 32'(npc);
						nw = 3;
						nb = st + 1;
						npc = wrap_addr(arg);
					end
				end
				OP_INT: begin
					if (!in_range(st + arg))
						err = ERR_RANGE;
					else
						nt = st + arg;
				end
				OP_JMP: npc = wrap_addr(arg - 1);
				OP_JPC: begin
					if (!in_range(st - 1))
						err = ERR_RANGE;
					else begin
						if (stk[st] == 0)
							npc = wrap_addr(arg - 1);
						nt = st - 1;
					end
				end
				default: err = ERR_INSTR;
			endcase
		end
		stops = (err != ERR_NONE) || (nb == 0);
		if (commit) begin
			pc = npc;
			if (err != ERR_NONE) begin
				erg = err;
				hlt = 1;
			end else begin
				for (int i = 0; i < nw; i++)
					stk[wa[i]] = wd[i];
				st = nt;
				fb = nb;
				if (fb == 0)
					hlt = 1;
			end
		end
	endfunction

	function automatic step_result_t predict_step(logic [3:0] iop, logic [3:0] ilvl,
			logic [31:0] iarg);
		logic [1:0] e;
		bit s;
		step_result_t r;
		if (!hlt)
			run_instr(iop, ilvl, iarg, 1, e, s);
		r.pc = pc[9:0];
		r.top = stk[st % STACK_DEPTH];
		r.halted = hlt;
		r.final_val = stk[1];
		r.err = erg;
		return r;
	endfunction

	// Offers one instruction and records its expected result on transfer.
	task automatic send(logic [3:0] iop, logic [3:0] ilvl, logic [31:0] iarg,
			bit typed = 0, step_result_t want = '0);
		step_result_t r;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= iop;
		level <= ilvl;
		argument <= iarg;
		do
			@(posedge clk);
		while (!in_ready);
		r = predict_step(iop, ilvl, iarg);
		pending_results.push_back(typed ? want : r);
	endtask

	// Builds a random instruction that keeps the machine running, or a LIT of a random value after 200 failed tries.
	task automatic pick_instr(output logic [3:0] iop, output logic [3:0] ilvl,
			output logic [31:0] iarg);
		logic [1:0] e;
		bit s;
		logic [31:0] codes [6] = '{OPR_RTN, OPR_ADD, OPR_SUB, OPR_MUL, OPR_NEQ, OPR_GTR};
		for (int tries = 0; tries < 200; tries++) begin
			iop = 4'($urandom_range(0, 7));
			ilvl = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 2)) : 4'($urandom);
			case (iop)
				OP_LIT: iarg = ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(0, 1));
				OP_OPR: iarg = codes[$urandom_range(0, 5)];
				OP_LOD, OP_STO: iarg = 32'(int'($urandom_range(0, 8)) - 2);
				OP_CAL, OP_JMP, OP_JPC: iarg = $urandom;
				default: iarg = (st > 700) ? -32'($urandom_range(1, 60))
				                           : 32'(int'($urandom_range(0, 10)) - 4);
			endcase
			run_instr(iop, ilvl, iarg, 0, e, s);
			if (!s)
				return;
		end
		iop = OP_LIT;
		ilvl = '0;
		iarg = $urandom;
	endtask

	// Receiver: random stalls, plus long hold-offs on request.
	always @(posedge clk) begin
		if (holds_done < hold_reqs) begin
			holds_done++;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transfer pc=%0d", $time, next_pc);
				errors++;
			end else begin
				step_result_t w;
				w = pending_results.pop_front();
				if (next_pc !== w.pc) begin
					$display("%0t: next_pc expected %0d, got %0d", $time, w.pc, next_pc);
					errors++;
				end
				if (top_value !== w.top) begin
					$display("%0t: top_value expected %h, got %h", $time, w.top, top_value);
					errors++;
				end
				if (halted !== w.halted) begin
					$display("%0t: halted expected %b, got %b", $time, w.halted, halted);
					errors++;
				end
				if (final_value !== w.final_val) begin
					$display("%0t: final_value expected %h, got %h", $time, w.final_val,
						final_value);
					errors++;
				end
				if (error_code !== w.err) begin
					$display("%0t: error_code expected %0d, got %0d", $time, w.err, error_code);
					errors++;
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		table_row_t rows [24];
		logic [3:0] iop, ilvl;
		logic [31:0] iarg;
		int phase_idle [4] = '{0, 66, 0, 23};
		int phase_stall [4] = '{0, 0, 66, 23};

		for (int i = 0; i < STACK_DEPTH; i++)
			stk[i] = 32'd0;
		stk[0] = 32'hFFFF_FFFF;
		fb = 1;
		st = 0;
		pc = 0;
		hlt = 0;
		erg = ERR_NONE;

		rows = '{
			'{OP_LIT, 0, 32'd5,         1, '{10'd1, 32'd5, 1'b0, 32'd5, ERR_NONE}},
			'{OP_LIT, 0, 32'h8000_0000, 1, '{10'd2, 32'h8000_0000, 1'b0, 32'd5, ERR_NONE}},
			'{OP_LIT, 0, 32'h7FFF_FFFF, 0, '0},
			'{OP_OPR, 0, OPR_ADD,       0, '0},
			'{OP_LIT, 0, 32'hFFFF_FFFF, 0, '0},
			'{OP_OPR, 0, OPR_SUB,       0, '0},
			'{OP_LIT, 0, 32'd3,         0, '0},
			'{OP_OPR, 0, OPR_MUL,       0, '0},
			'{OP_LIT, 0, 32'd0,         0, '0},
			'{OP_OPR, 0, OPR_NEQ,       0, '0},
			'{OP_LIT, 0, 32'h8000_0000, 0, '0},
			'{OP_OPR, 0, OPR_GTR,       0, '0},
			'{OP_INT, 0, 32'd4,         0, '0},
			'{OP_LOD, 0, 32'd1,         0, '0},
			'{OP_STO, 0, 32'd3,         0, '0},
			'{OP_CAL, 0, 32'd100,       0, '0},
			'{OP_INT, 0, 32'd5,         0, '0},
			'{OP_LOD, 1, 32'd0,         0, '0},
			'{OP_STO, 1, 32'd2,         0, '0},
			'{OP_LIT, 0, 32'd0,         0, '0},
			'{OP_JPC, 0, 32'd0,         0, '0},
			'{OP_JMP, 0, 32'h7FFF_FFFF, 0, '0},
			'{OP_OPR, 0, OPR_RTN,       0, '0},
			'{OP_LIT, 0, 32'h55AA_55AA, 0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send(rows[i].op, rows[i].level, rows[i].arg, rows[i].typed, rows[i].want);

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < 250; n++) begin
				pick_instr(iop, ilvl, iarg);
				send(iop, ilvl, iarg);
			end
		end

		// Sender waits for every outstanding result.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);

		// Long receiver hold-off while the sender keeps offering.
		idle_pct = 0;
		stall_pct = 10;
		hold_reqs++;
		for (int n = 0; n < 80; n++) begin
			pick_instr(iop, ilvl, iarg);
			send(iop, ilvl, iarg);
		end

		// One terminal fault; afterwards the machine ignores its input.
		case ($urandom_range(0, 3))
			0: send(4'd8, 4'($urandom), $urandom);
			1: send(4'($urandom_range(9, 15)), 4'($urandom), $urandom);
			2: send(OP_OPR, 4'($urandom), 32'd1);
			default: send(OP_INT, 4'($urandom), 32'h8000_0000);
		endcase
		stall_pct = 23;
		idle_pct = 23;
		for (int n = 0; n < 40; n++)
			send(4'($urandom), 4'($urandom), $urandom);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
